@@ rtl/rsf_pkg.sv @@
// ----------------------------------------------------------------------------
// rsf_pkg: shared types and constants of the RGB sharpen filter
// Pixel layout, register indexes, item kinds and arithmetic widths.
// ----------------------------------------------------------------------------
package rsf_pkg;

    // one color channel and one packed pixel (blue in the lowest byte)
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // row ring: four row banks, selected by the low bits of the row number
    localparam int RING_ROWS = 4;
    localparam int BANK_W    = $clog2(RING_ROWS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int STR_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH     = 2'd2;

    localparam int               FRAME_WIDTH_DEF  = 640;
    localparam int               FRAME_HEIGHT_DEF = 480;
    localparam logic [STR_W-1:0] STRENGTH_DEF     = 4'd3;

    // item kinds on the input tuser
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // filter arithmetic: value formed in eighths
    localparam int FRAC_BITS  = 3;
    localparam int NSUM_W     = CH_W + 3;                  // sum of eight neighbors
    localparam int CWT_W      = STR_W + 1;                 // strength + 1
    localparam int CPROD_W    = CWT_W + CH_W;
    localparam int POS_W      = CPROD_W + FRAC_BITS;
    localparam int NEG_W      = STR_W + NSUM_W;
    localparam int ACC_W      = POS_W + 1;
    localparam logic [CH_W-1:0] SAT_MAX = 8'd255;

endpackage

@@ rtl/rsf_line_ram.sv @@
// ----------------------------------------------------------------------------
// rsf_line_ram: one row bank of the row ring
// One write port and two registered read ports, read data held when disabled.
// ----------------------------------------------------------------------------
module rsf_line_ram #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic           aclk,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  rsf_pkg::rgb_t  wr_data,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr_a,
    input  logic [AW-1:0]  rd_addr_b,
    output rsf_pkg::rgb_t  rd_data_a,
    output rsf_pkg::rgb_t  rd_data_b
);
    import rsf_pkg::*;

    rgb_t ram_reg [DEPTH];
    rgb_t rd_a_reg;
    rgb_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= ram_reg[rd_addr_a];
            rd_b_reg <= ram_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ rtl/rsf_channel_calc.sv @@
// ----------------------------------------------------------------------------
// rsf_channel_calc: sharpening arithmetic of one color channel
// acc = 8*(strength+1)*center - strength*neighbors, clip at 0, /8, cap at 255.
// ----------------------------------------------------------------------------
module rsf_channel_calc (
    input  logic [rsf_pkg::STR_W-1:0]  strength,
    input  logic [rsf_pkg::CH_W-1:0]   center,
    input  logic [rsf_pkg::NSUM_W-1:0] nsum,
    output logic [rsf_pkg::CH_W-1:0]   result
);
    import rsf_pkg::*;

    logic [CWT_W-1:0]       center_wt;
    logic [CPROD_W-1:0]     center_prod;
    logic [POS_W-1:0]       pos_term;
    logic [NEG_W-1:0]       neg_term;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-FRAC_BITS-1:0] quot;

    assign center_wt   = CWT_W'(strength) + CWT_W'(1);
    assign center_prod = CPROD_W'(center_wt) * CPROD_W'(center);
    assign pos_term    = {center_prod, {FRAC_BITS{1'b0}}};
    assign neg_term    = NEG_W'(strength) * NEG_W'(nsum);
    assign acc         = $signed({1'b0, pos_term}) - $signed(ACC_W'(neg_term));
    assign quot        = acc[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (acc[ACC_W-1] || (acc == '0)) begin
            result = '0;
        end else if (quot > (ACC_W-FRAC_BITS)'(SAT_MAX)) begin
            result = SAT_MAX;
        end else begin
            result = quot[CH_W-1:0];
        end
    end

endmodule

@@ rtl/rgb_sharpen_3x3_filter.sv @@
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_filter: 3x3 sharpening filter on an RGB pixel stream
// Raster-order pixels in, sharpened raster-order pixels out, drain items
// flush the tail of a frame.
// ----------------------------------------------------------------------------
// The block takes one item per clock on the s_ channel and gives at most one
// result per item on the m_ channel. Result k of a frame is produced by the
// item that carries pixel k + frame_width + 1; once the whole frame is in,
// send drain items (tuser high), one per remaining result. A result passes
// the row-bank read register, the window register and the output register
// before it appears on m_, and the pipeline keeps one item per clock as
// long as m_tready stays high; a stall on m_ holds each stage and backs up
// to s_tready only when every stage is full. The rows live in four
// banks of MAX_WIDTH pixels, each with one write and two read ports, so a
// pixel write and the two column reads of an output are done in the same
// cycle; the bank read port is what sets the one-pixel-per-clock figure. Row
// banks need no clearing after reset: a frame reads only pixels it has
// already written. Configuration writes to a known register (cfg_ready is
// always high) restart the frame in progress and are meant for an idle
// block. tlast on m_ marks the last pixel of the frame. Borders mirror at
// the top and left and replicate the edge at the bottom and right.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input pixel stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rsf_pkg::PIX_W-1:0]       s_tdata,   // blue, green, red
    input  logic                            s_tuser,   // action (1: drain item)

    // sharpened pixel stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rsf_pkg::PIX_W-1:0]       m_tdata,   // blue_out, green_out, red_out
    output logic                            m_tlast,   // frame_end

    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rsf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);        // column address
    localparam int WW = $clog2(MAX_WIDTH + 1);    // width value, 1..MAX_WIDTH
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // row value, 0..MAX_HEIGHT
    localparam int DW = $clog2(MAX_WIDTH + 2);    // lead of input over output
    localparam int WIDTH_RST  = (FRAME_WIDTH_DEF > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_DEF;
    localparam int HEIGHT_RST = (FRAME_HEIGHT_DEF > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : FRAME_HEIGHT_DEF;

    // control that travels with an output from the bank read to the window stage
    typedef struct packed {
        logic [BANK_W-1:0] bank_up;
        logic [BANK_W-1:0] bank_mid;
        logic [BANK_W-1:0] bank_low;
        logic [BANK_W-1:0] wr_bank;
        logic              x_first;
        logic              last;
        logic              hit_c;
        logic              hit_r;
    } s1_ctrl_t;

    // pick one bank's read data; arms use fixed indexes
    function automatic rgb_t bank_pick(input logic [BANK_W-1:0] sel,
                                       input rgb_t d0, input rgb_t d1,
                                       input rgb_t d2, input rgb_t d3);
        rgb_t v;
        case (sel)
            2'd0:    v = d0;
            2'd1:    v = d1;
            2'd2:    v = d2;
            2'd3:    v = d3;
            default: v = d0;
        endcase
        return v;
    endfunction

    function automatic logic [NSUM_W-1:0] add8(
        input logic [CH_W-1:0] a0, input logic [CH_W-1:0] a1,
        input logic [CH_W-1:0] a2, input logic [CH_W-1:0] a3,
        input logic [CH_W-1:0] a4, input logic [CH_W-1:0] a5,
        input logic [CH_W-1:0] a6, input logic [CH_W-1:0] a7);
        return NSUM_W'(a0) + NSUM_W'(a1) + NSUM_W'(a2) + NSUM_W'(a3)
             + NSUM_W'(a4) + NSUM_W'(a5) + NSUM_W'(a6) + NSUM_W'(a7);
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [WW-1:0]    width_reg;
    logic [HW-1:0]    height_reg;
    logic [STR_W-1:0] strength_reg;

    logic [AW-1:0]    in_col_reg,  in_col_next;
    logic [HW-1:0]    in_row_reg,  in_row_next;
    logic [DW-1:0]    lead_reg,    lead_next;
    logic [AW-1:0]    out_x_reg,   out_x_next;
    logic [HW-1:0]    out_y_reg,   out_y_next;

    logic             s1_valid_reg;
    s1_ctrl_t         s1_ctrl_reg;
    rgb_t             s1_wdata_reg;

    logic             s2_valid_reg;
    rgb_t             s2_center_reg;
    logic [NSUM_W-1:0] s2_nsum_red_reg;
    logic [NSUM_W-1:0] s2_nsum_green_reg;
    logic [NSUM_W-1:0] s2_nsum_blue_reg;
    logic             s2_last_reg;
    rgb_t             last_c_reg [3];

    logic             m_tvalid_reg;
    rgb_t             m_tdata_reg;
    logic             m_tlast_reg;

    // ------------------------------------------------------------------
    // stage enables: a stage loads when it is empty or its content moves on
    // ------------------------------------------------------------------
    logic ce1, ce2, ce3;

    assign ce3 = !m_tvalid_reg || m_tready;
    assign ce2 = !s2_valid_reg || ce3;
    assign ce1 = !s1_valid_reg || ce2;

    assign s_tready  = ce1;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // item decode and frame position
    // ------------------------------------------------------------------
    logic              s_accept;
    logic              cfg_accept;
    logic              cfg_known;
    logic              frame_in;
    logic              pix_take;
    logic              drain_take;
    logic              col_wrap;
    logic              lead_full;
    logic              x_last;
    logic              out_last;
    logic              emit;
    rgb_t              in_pix;
    logic [HW-1:0]     row_up;
    logic [HW-1:0]     row_low;
    logic [WW-1:0]     col_r_full;
    logic [AW-1:0]     col_r;
    logic              hit_c;
    logic              hit_r;

    assign in_pix     = s_tdata;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_known  = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT) ||
                        (cfg_index == REG_STRENGTH);

    // whole frame is in once the row count reaches the height
    assign frame_in   = (in_row_reg >= height_reg);
    // drop pixels past the frame and drains that come too early
    assign pix_take   = s_accept && (s_tuser == ACT_PIXEL) && !frame_in;
    assign drain_take = s_accept && (s_tuser == ACT_DRAIN) && frame_in;

    assign col_wrap   = (WW'(in_col_reg) + WW'(1) >= width_reg);
    // a pixel gives a result once input leads output by width+2
    assign lead_full  = (lead_reg >= DW'(width_reg) + DW'(1));
    assign emit       = drain_take || (pix_take && lead_full);

    assign x_last     = (WW'(out_x_reg) + WW'(1) >= width_reg);
    assign out_last   = x_last && (out_y_reg + HW'(1) >= height_reg);

    // neighbor rows: mirror above the top, replicate below the bottom
    assign row_up  = (out_y_reg == '0) ? ((height_reg > HW'(1)) ? HW'(1) : '0)
                                       : out_y_reg - HW'(1);
    assign row_low = (out_y_reg + HW'(1) >= height_reg) ? height_reg - HW'(1)
                                                        : out_y_reg + HW'(1);
    // right neighbor column, replicated at the right edge
    assign col_r_full = x_last ? width_reg - WW'(1) : WW'(out_x_reg) + WW'(1);
    assign col_r      = col_r_full[AW-1:0];

    // the pixel written this cycle may be one of the columns read now
    assign hit_c = pix_take && (in_col_reg == out_x_reg);
    assign hit_r = pix_take && (in_col_reg == col_r);

    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        lead_next   = lead_reg;
        out_x_next  = out_x_reg;
        out_y_next  = out_y_reg;
        if (pix_take) begin
            if (col_wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + HW'(1);
            end else begin
                in_col_next = in_col_reg + AW'(1);
            end
            // lead holds at its ceiling: one in, one out
            if (!lead_full) begin
                lead_next = lead_reg + DW'(1);
            end
        end
        if (emit) begin
            if (out_last) begin
                // frame done: restart all positions
                in_col_next = '0;
                in_row_next = '0;
                lead_next   = '0;
                out_x_next  = '0;
                out_y_next  = '0;
            end else if (x_last) begin
                out_x_next = '0;
                out_y_next = out_y_reg + HW'(1);
            end else begin
                out_x_next = out_x_reg + AW'(1);
            end
        end
        if (cfg_accept && cfg_known) begin
            in_col_next = '0;
            in_row_next = '0;
            lead_next   = '0;
            out_x_next  = '0;
            out_y_next  = '0;
        end
    end

    // effective frame size of a register write: 0 acts as 1, cap at the maximum
    logic [FW_W-1:0] fw_raw;
    logic [FH_W-1:0] fh_raw;
    logic [WW-1:0]   width_wr;
    logic [HW-1:0]   height_wr;

    assign fw_raw = cfg_data[FW_W-1:0];
    assign fh_raw = cfg_data[FH_W-1:0];

    always_comb begin
        if (fw_raw == '0) begin
            width_wr = WW'(1);
        end else if (32'(fw_raw) > 32'(MAX_WIDTH)) begin
            width_wr = WW'(MAX_WIDTH);
        end else begin
            width_wr = WW'(fw_raw);
        end
        if (fh_raw == '0) begin
            height_wr = HW'(1);
        end else if (32'(fh_raw) > 32'(MAX_HEIGHT)) begin
            height_wr = HW'(MAX_HEIGHT);
        end else begin
            height_wr = HW'(fh_raw);
        end
    end

    // ------------------------------------------------------------------
    // row banks: write the incoming pixel, read center and right columns
    // ------------------------------------------------------------------
    rgb_t rd_c [RING_ROWS];
    rgb_t rd_r [RING_ROWS];

    for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
        rsf_line_ram #(
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .aclk      (aclk),
            .wr_en     (pix_take && (in_row_reg[BANK_W-1:0] == BANK_W'(b))),
            .wr_addr   (in_col_reg),
            .wr_data   (in_pix),
            .rd_en     (ce1),
            .rd_addr_a (out_x_reg),
            .rd_addr_b (col_r),
            .rd_data_a (rd_c[b]),
            .rd_data_b (rd_r[b])
        );
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WW'(WIDTH_RST);
            height_reg   <= HW'(HEIGHT_RST);
            strength_reg <= STRENGTH_DEF;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            lead_reg     <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_accept) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg    <= width_wr;
                    REG_FRAME_HEIGHT: height_reg   <= height_wr;
                    REG_STRENGTH:     strength_reg <= cfg_data[STR_W-1:0];
                    default:          ;
                endcase
            end
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            lead_reg   <= lead_next;
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            if (ce1) begin
                s1_valid_reg <= emit;
            end
            if (ce2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ce3) begin
                m_tvalid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: control beside the bank read data
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ce1) begin
            s1_ctrl_reg.bank_up  <= row_up[BANK_W-1:0];
            s1_ctrl_reg.bank_mid <= out_y_reg[BANK_W-1:0];
            s1_ctrl_reg.bank_low <= row_low[BANK_W-1:0];
            s1_ctrl_reg.wr_bank  <= in_row_reg[BANK_W-1:0];
            s1_ctrl_reg.x_first  <= (out_x_reg == '0);
            s1_ctrl_reg.last     <= out_last;
            s1_ctrl_reg.hit_c    <= hit_c;
            s1_ctrl_reg.hit_r    <= hit_r;
            s1_wdata_reg         <= in_pix;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: assemble the 3x3 window, sum the neighbors
    // ------------------------------------------------------------------
    logic [BANK_W-1:0] role_bank [3];
    rgb_t              win_l [3];
    rgb_t              win_c [3];
    rgb_t              win_r [3];

    assign role_bank[0] = s1_ctrl_reg.bank_up;
    assign role_bank[1] = s1_ctrl_reg.bank_mid;
    assign role_bank[2] = s1_ctrl_reg.bank_low;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (s1_ctrl_reg.hit_c && (s1_ctrl_reg.wr_bank == role_bank[r])) begin
                win_c[r] = s1_wdata_reg;
            end else begin
                win_c[r] = bank_pick(role_bank[r], rd_c[0], rd_c[1], rd_c[2], rd_c[3]);
            end
            if (s1_ctrl_reg.hit_r && (s1_ctrl_reg.wr_bank == role_bank[r])) begin
                win_r[r] = s1_wdata_reg;
            end else begin
                win_r[r] = bank_pick(role_bank[r], rd_r[0], rd_r[1], rd_r[2], rd_r[3]);
            end
            // left column mirrors the right one at the left edge
            win_l[r] = s1_ctrl_reg.x_first ? win_r[r] : last_c_reg[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce2) begin
            s2_center_reg     <= win_c[1];
            s2_last_reg       <= s1_ctrl_reg.last;
            s2_nsum_red_reg   <= add8(win_l[0].red,  win_c[0].red,  win_r[0].red,
                                      win_l[1].red,  win_r[1].red,
                                      win_l[2].red,  win_c[2].red,  win_r[2].red);
            s2_nsum_green_reg <= add8(win_l[0].green, win_c[0].green, win_r[0].green,
                                      win_l[1].green, win_r[1].green,
                                      win_l[2].green, win_c[2].green, win_r[2].green);
            s2_nsum_blue_reg  <= add8(win_l[0].blue, win_c[0].blue, win_r[0].blue,
                                      win_l[1].blue, win_r[1].blue,
                                      win_l[2].blue, win_c[2].blue, win_r[2].blue);
            // center column becomes the left column of the next output
            if (s1_valid_reg) begin
                for (int r = 0; r < 3; r++) begin
                    last_c_reg[r] <= win_c[r];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: channel arithmetic into the output register
    // ------------------------------------------------------------------
    rgb_t calc_pix;

    rsf_channel_calc u_calc_red (
        .strength (strength_reg),
        .center   (s2_center_reg.red),
        .nsum     (s2_nsum_red_reg),
        .result   (calc_pix.red)
    );

    rsf_channel_calc u_calc_green (
        .strength (strength_reg),
        .center   (s2_center_reg.green),
        .nsum     (s2_nsum_green_reg),
        .result   (calc_pix.green)
    );

    rsf_channel_calc u_calc_blue (
        .strength (strength_reg),
        .center   (s2_center_reg.blue),
        .nsum     (s2_nsum_blue_reg),
        .result   (calc_pix.blue)
    );

    always_ff @(posedge aclk) begin
        if (ce3) begin
            m_tdata_reg <= calc_pix;
            m_tlast_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RGB sharpen 3x3 filter
// Drives pixel frames, drain items and register writes with random gaps and
// back-pressure, predicts every sharpened pixel and compares it on arrival.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rsf_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 32;    // pipeline is three deep; leave ample room
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
    localparam int LONG_HOLD     = 400;   // receiver hold-off in the pressure phase
    localparam int RANDOM_ITEMS  = 1000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        rgb_t pix;
        logic last;
    } sharp_pixel_t;

    // ------------------------------------------------------------------------
    // Frame sharpener: tracks rows, position and registers, and keeps the
    // sharpened pixels that are still to come out of the block.
    // ------------------------------------------------------------------------
    class frame_sharpener;
        rgb_t         row_ring[RING_ROWS][MAX_W];
        int           width_reg, height_reg, strength_reg;
        int           in_col, in_row, out_count;
        sharp_pixel_t awaited_pixels[$];
        int unsigned  consumed;
        int unsigned  mismatches;

        function new();
            width_reg    = FRAME_WIDTH_DEF;
            height_reg   = FRAME_HEIGHT_DEF;
            strength_reg = STRENGTH_DEF;
            in_col       = 0;
            in_row       = 0;
            out_count    = 0;
            consumed     = 0;
            mismatches   = 0;
            foreach (row_ring[r, c]) row_ring[r][c] = '0;
        endfunction

        function int active_width();
            if (width_reg == 0) return 1;
            return (width_reg > MAX_W) ? MAX_W : width_reg;
        endfunction

        function int active_height();
            if (height_reg == 0) return 1;
            return (height_reg > MAX_H) ? MAX_H : height_reg;
        endfunction

        function int frame_pixels();
            return active_width() * active_height();
        endfunction

        function int results_left();
            return frame_pixels() - out_count;
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH:  width_reg    = int'(val[FW_W-1:0]);
                REG_FRAME_HEIGHT: height_reg   = int'(val[FH_W-1:0]);
                REG_STRENGTH:     strength_reg = int'(val[STR_W-1:0]);
                default:          return;
            endcase
            in_col    = 0;
            in_row    = 0;
            out_count = 0;
        endfunction

        // mirror at the top/left first, then replicate the bottom/right edge
        function int fold(int c, int n);
            if (c < 0) c = -c;
            if (c >= n) c = n - 1;
            return c;
        endfunction

        function logic [CH_W-1:0] sharpen_channel(int y, int x, int w, int h, int ch);
            int               nsum, center, acc;
            logic [CH_W-1:0]  v;
            rgb_t             p;
            nsum   = 0;
            center = 0;
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    p = row_ring[fold(y + dy, h) % RING_ROWS][fold(x + dx, w) % MAX_W];
                    case (ch)
                        0:       v = p.blue;
                        1:       v = p.green;
                        default: v = p.red;
                    endcase
                    if (dy == 0 && dx == 0) center = int'(v);
                    else nsum += int'(v);
                end
            end
            acc = 8 * (strength_reg + 1) * center - strength_reg * nsum;
            if (acc <= 0) return '0;
            acc = acc / 8;
            return (acc > 255) ? 8'd255 : acc[CH_W-1:0];
        endfunction

        function void produce();
            sharp_pixel_t r;
            int           w, h, y, x;
            w = active_width();
            h = active_height();
            y = out_count / w;
            x = out_count % w;
            r.pix.blue  = sharpen_channel(y, x, w, h, 0);
            r.pix.green = sharpen_channel(y, x, w, h, 1);
            r.pix.red   = sharpen_channel(y, x, w, h, 2);
            out_count++;
            r.last = (out_count >= w * h);
            if (r.last) begin
                out_count = 0;
                in_col    = 0;
                in_row    = 0;
            end
            awaited_pixels = {awaited_pixels, r};
        endfunction

        function void accept_item(logic action, rgb_t pix);
            int w, h;
            bit complete;
            w = active_width();
            h = active_height();
            complete = (in_row >= h);
            if (action == ACT_DRAIN) begin
                // a drain before the frame is complete is dropped
                if (complete) begin
                    consumed++;
                    produce();
                end
                return;
            end
            // a pixel past the end of a complete frame is dropped
            if (complete) return;
            consumed++;
            row_ring[in_row % RING_ROWS][in_col % MAX_W] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (in_row * w + in_col >= out_count + w + 2) produce();
        endfunction

        function void note_mismatch();
            mismatches++;
        endfunction

        function void compare_output(rgb_t got, logic last);
            sharp_pixel_t e;
            if (awaited_pixels.size() == 0) begin
                note_mismatch();
                if (mismatches <= 10)
                    $display("unexpected output: r=%0d g=%0d b=%0d last=%0b",
                             got.red, got.green, got.blue, last);
                return;
            end
            e = awaited_pixels.pop_front();
            if (got.red !== e.pix.red || got.green !== e.pix.green ||
                got.blue !== e.pix.blue || last !== e.last) begin
                note_mismatch();
                if (mismatches <= 10)
                    $display(
                        "mismatch: exp r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                        e.pix.red, e.pix.green, e.pix.blue, e.last,
                        got.red, got.green, got.blue, last);
            end
        endfunction

        function void flush_leftover();
            if (awaited_pixels.size() != 0) begin
                mismatches += awaited_pixels.size();
                $display("%0d expected outputs never arrived", awaited_pixels.size());
                awaited_pixels.delete();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals: every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit             gaps_on  = 1'b1;   // random idling on both sides
    int             hold_len = 0;      // one-shot long hold-off for the receiver
    frame_sharpener sb = new();

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    rgb_sharpen_3x3_filter #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // blue, green, red
        .s_tuser   (s_tuser),     // action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // blue_out, green_out, red_out
        .m_tlast   (m_tlast),     // frame_end
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Driver tasks. Inputs change on the falling edge; handshakes are sampled
    // on the rising edge.
    // ------------------------------------------------------------------------

    // Offer one item after a random gap, hold it until the transfer.
    task automatic send_item(input logic action, input rgb_t pix);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= action;
        do @(posedge aclk); while (!s_tready);
        sb.accept_item(action, pix);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop the input valid, wait for every awaited pixel, then let the
    // pipeline run dry of items that give no output.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers; unused bits of the width and strength data carry random noise.
    task automatic configure(input int w_raw, input int h_raw, input int s_raw);
        logic [CFG_DATA_W-1:0] val;
        val = CFG_DATA_W'($urandom);
        val[FW_W-1:0] = FW_W'(w_raw);
        write_reg(REG_FRAME_WIDTH, val);
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
        val = CFG_DATA_W'($urandom);
        val[STR_W-1:0] = STR_W'(s_raw);
        write_reg(REG_STRENGTH, val);
        // an unused index must leave all three registers and frame position alone
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    function automatic rgb_t rand_pixel();
        rgb_t p;
        p = rgb_t'($urandom);
        // push channels to the rails often, to hit saturation and clipping
        if ($urandom_range(0, 3) == 0) begin
            p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    // Send one whole frame and drain it. Noisy frames add early drains and
    // pixels past the end, which the block must drop.
    task automatic run_frame(input bit noisy);
        int total, left;
        total = sb.frame_pixels();
        for (int i = 0; i < total; i++) begin
            if (noisy && $urandom_range(0, 15) == 0) send_item(ACT_DRAIN, rand_pixel());
            send_item(ACT_PIXEL, rand_pixel());
        end
        if (noisy) repeat ($urandom_range(1, 2)) send_item(ACT_PIXEL, rand_pixel());
        left = sb.results_left();
        repeat (left) send_item(ACT_DRAIN, rand_pixel());
        if (noisy && $urandom_range(0, 1) == 0) send_item(ACT_DRAIN, rand_pixel());
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls per transfer, plus the one-shot hold-off.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned pause;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            pause = gaps_on ? $urandom_range(0, 7) : 0;
            pause += hold_len;
            hold_len = 0;
            if (pause != 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.compare_output(rgb_t'(m_tdata), m_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no channel moves for too long.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          target, phase, kind, w_raw, h_raw, s_raw, total, cut;
        bit          tall, wide;
        rgb_t        pix;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: 4x3 frame at full strength with rail-to-rail edges, so
        // both clipping to zero and saturation appear, plus dropped items.
        gaps_on = 1'b0;
        wait_idle();
        configure(4, 3, 15);
        send_item(ACT_DRAIN, rand_pixel());          // early drain, dropped
        for (int i = 0; i < 12; i++) begin
            pix.red   = (((i % 4) + (i / 4)) % 2 != 0) ? 8'hFF : 8'h00;
            pix.green = (i / 4 == 0) ? 8'hFF : 8'h00;
            pix.blue  = (i == 0) ? 8'hFF : ((i == 11) ? 8'h00 : 8'($urandom));
            send_item(ACT_PIXEL, pix);
        end
        send_item(ACT_PIXEL, rand_pixel());          // past the end, dropped
        total = sb.results_left();
        repeat (total) send_item(ACT_DRAIN, rand_pixel());

        // zero size acts as one pixel; zero strength passes the pixel through
        wait_idle();
        configure(0, 0, 0);
        send_item(ACT_PIXEL, rgb_t'(24'hFF00A5));
        send_item(ACT_DRAIN, rand_pixel());

        // Random phases, mostly small frames.
        target = sb.consumed + RANDOM_ITEMS;
        phase  = 0;
        while (sb.consumed < target) begin
            wait_idle();
            tall = ($urandom_range(0, 19) == 0);
            wide = !tall && ($urandom_range(0, 19) == 0);
            case ($urandom_range(0, 9))
                0:       w_raw = 0;
                1:       w_raw = $urandom_range(9, 24);
                default: w_raw = $urandom_range(1, 8);
            endcase
            h_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            if (tall) h_raw = $urandom_range(4096, 8191);
            if (wide) w_raw = $urandom_range(1024, 2047);
            case ($urandom_range(0, 4))
                0:       s_raw = 0;
                1:       s_raw = 15;
                default: s_raw = $urandom_range(0, 15);
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);

            if (phase == 1) begin
                // Pressure: the receiver holds off while the sender streams,
                // so the pipeline fills and back-pressures the input.
                configure(16, 8, s_raw);
                gaps_on  = 1'b0;
                hold_len = LONG_HOLD;
                run_frame(1'b0);
            end else begin
                configure(w_raw, h_raw, s_raw);
                kind = $urandom_range(0, 9);
                if (tall || wide || kind < 2) begin
                    // broken frame: stop partway, the next write discards it
                    total = sb.frame_pixels();
                    cut   = $urandom_range(1, (total < 60) ? total : 60);
                    repeat (cut) send_item(ACT_PIXEL, rand_pixel());
                end else begin
                    repeat ($urandom_range(1, 3)) run_frame(kind < 4);
                end
            end
            phase++;
        end

        // Hold inputs, wait for the tail, then report.
        wait_idle();
        sb.flush_leftover();
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rsf_pkg.sv
rtl/rsf_line_ram.sv
rtl/rsf_channel_calc.sv
rtl/rgb_sharpen_3x3_filter.sv
tb/sv/testbench.sv
